FILE: rtl/ubx_pkg.sv
package ubx_pkg;

    localparam int BufferBytesDefault = 128;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;
    localparam logic [7:0] CLS_NAV     = 8'h01;
    localparam logic [7:0] ID_PVT      = 8'h07;
    localparam logic [7:0] CLS_ACK     = 8'h05;
    localparam logic [7:0] ID_ACK      = 8'h01;
    localparam logic [7:0] ID_NAK      = 8'h00;
    localparam logic [7:0] CLS_MON     = 8'h0A;
    localparam logic [7:0] ID_RF       = 8'h38;
    localparam logic [15:0] PVT_BYTES    = 16'd92;
    localparam logic [15:0] RF_MIN_BYTES = 16'd28;
    localparam logic [6:0]  PVT_FIX_OFF  = 7'd20;

    localparam logic [2:0] KIND_PVT   = 3'd0;
    localparam logic [2:0] KIND_ACK   = 3'd1;
    localparam logic [2:0] KIND_NAK   = 3'd2;
    localparam logic [2:0] KIND_RF    = 3'd3;
    localparam logic [2:0] KIND_OTHER = 3'd4;

    // one decoded field: offset, byte count, signedness
    typedef struct packed {
        logic [6:0] off;
        logic [2:0] size;
        logic       sgn;
    } field_desc_t;

    // frame summary handed from the byte parser to the field reader
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  cls;
        logic [7:0]  id;
        logic [15:0] len;
    } frame_info_t;

    function automatic field_desc_t field_desc(input logic [2:0] kind, input logic [4:0] idx);
        field_desc_t d;
        d = '{off: 7'd0, size: 3'd1, sgn: 1'b0};
        case (kind)
            KIND_PVT:
            begin
                case (idx)
                    5'd0:  d = '{7'd0,  3'd4, 1'b0};
                    5'd1:  d = '{7'd4,  3'd2, 1'b0};
                    5'd2:  d = '{7'd6,  3'd1, 1'b0};
                    5'd3:  d = '{7'd7,  3'd1, 1'b0};
                    5'd4:  d = '{7'd8,  3'd1, 1'b0};
                    5'd5:  d = '{7'd9,  3'd1, 1'b0};
                    5'd6:  d = '{7'd10, 3'd1, 1'b0};
                    5'd7:  d = '{7'd11, 3'd1, 1'b0};
                    5'd8:  d = '{7'd20, 3'd1, 1'b0};
                    5'd9:  d = '{7'd23, 3'd1, 1'b0};
                    5'd10: d = '{7'd24, 3'd4, 1'b1};
                    5'd11: d = '{7'd28, 3'd4, 1'b1};
                    5'd12: d = '{7'd36, 3'd4, 1'b1};
                    5'd13: d = '{7'd40, 3'd4, 1'b0};
                    5'd14: d = '{7'd44, 3'd4, 1'b0};
                    5'd15: d = '{7'd48, 3'd4, 1'b1};
                    5'd16: d = '{7'd52, 3'd4, 1'b1};
                    5'd17: d = '{7'd56, 3'd4, 1'b1};
                    5'd18: d = '{7'd76, 3'd2, 1'b0};
                    default: d = '{PVT_FIX_OFF, 3'd1, 1'b0};
                endcase
            end
            KIND_ACK, KIND_NAK:
            begin
                d = '{{6'd0, idx[0]}, 3'd1, 1'b0};
            end
            KIND_RF:
            begin
                case (idx)
                    5'd0:  d = '{7'd6,  3'd1, 1'b0};
                    5'd1:  d = '{7'd7,  3'd1, 1'b0};
                    5'd2:  d = '{7'd12, 3'd2, 1'b0};
                    5'd3:  d = '{7'd14, 3'd2, 1'b0};
                    default: d = '{7'd16, 3'd1, 1'b0};
                endcase
            end
            default: d = '{7'd0, 3'd1, 1'b0};
        endcase
        return d;
    endfunction

    function automatic logic [4:0] field_count(input logic [2:0] kind);
        logic [4:0] n;
        case (kind)
            KIND_PVT:           n = 5'd20;
            KIND_ACK, KIND_NAK: n = 5'd2;
            KIND_RF:            n = 5'd5;
            default:            n = 5'd1;
        endcase
        return n;
    endfunction

endpackage

FILE: rtl/ubx_byte_parser.sv
module ubx_byte_parser #(
    parameter int BUFFER_BYTES = ubx_pkg::BufferBytesDefault,
    parameter int AW = $clog2(BUFFER_BYTES)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic [7:0]           byte_value,
    output logic                 wr_en,
    output logic [AW-1:0]        wr_addr,
    output logic [7:0]           wr_data,
    output logic                 frame_done,
    output ubx_pkg::frame_info_t frame_info
);
    import ubx_pkg::*;

    typedef enum logic [8:0] {
        PH_SYNC1   = 9'b000000001,
        PH_SYNC2   = 9'b000000010,
        PH_CLASS   = 9'b000000100,
        PH_ID      = 9'b000001000,
        PH_LEN1    = 9'b000010000,
        PH_LEN2    = 9'b000100000,
        PH_PAYLOAD = 9'b001000000,
        PH_CKA     = 9'b010000000,
        PH_CKB     = 9'b100000000
    } phase_t;

    localparam logic [15:0] BufLen = 16'(BUFFER_BYTES);

    phase_t      phase_reg, phase_next;
    logic [7:0]  cls_reg, cls_next, id_reg, id_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] idx_reg, idx_next;
    logic [7:0]  sa_reg, sa_next, sb_reg, sb_next;
    logic [7:0]  sa_add;
    logic [15:0] full_len, idx_inc;
    logic        done_next;
    logic [2:0]  kind;

    assign sa_add   = sa_reg + byte_value;
    assign full_len = {byte_value, len_reg[7:0]};
    assign idx_inc  = idx_reg + 16'd1;

    always_comb
    begin
        phase_next = phase_reg;
        cls_next   = cls_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        sa_next    = sa_reg;
        sb_next    = sb_reg;
        done_next  = 1'b0;
        wr_en      = 1'b0;
        if (take)
        begin
            case (phase_reg)
                PH_SYNC1: if (byte_value == SYNC_FIRST) phase_next = PH_SYNC2;
                PH_SYNC2:
                begin
                    if (byte_value == SYNC_SECOND) phase_next = PH_CLASS;
                    else if (byte_value != SYNC_FIRST) phase_next = PH_SYNC1;
                end
                PH_CLASS:
                begin
                    cls_next = byte_value;
                    sa_next = byte_value;
                    sb_next = byte_value;
                    phase_next = PH_ID;
                end
                PH_ID:
                begin
                    id_next = byte_value;
                    sa_next = sa_add;
                    sb_next = sb_reg + sa_add;
                    phase_next = PH_LEN1;
                end
                PH_LEN1:
                begin
                    len_next = {8'd0, byte_value};
                    sa_next = sa_add;
                    sb_next = sb_reg + sa_add;
                    phase_next = PH_LEN2;
                end
                PH_LEN2:
                begin
                    len_next = full_len;
                    sa_next = sa_add;
                    sb_next = sb_reg + sa_add;
                    idx_next = 16'd0;
                    if (full_len > BufLen) phase_next = PH_SYNC1;
                    else if (full_len == 16'd0) phase_next = PH_CKA;
                    else phase_next = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    wr_en = 1'b1;
                    idx_next = idx_inc;
                    sa_next = sa_add;
                    sb_next = sb_reg + sa_add;
                    if (idx_inc >= len_reg) phase_next = PH_CKA;
                end
                PH_CKA: phase_next = (byte_value == sa_reg) ? PH_CKB : PH_SYNC1;
                PH_CKB:
                begin
                    phase_next = PH_SYNC1;
                    done_next = (byte_value == sb_reg);
                end
                default: phase_next = PH_SYNC1;
            endcase
        end
    end

    assign wr_addr = idx_reg[AW-1:0];
    assign wr_data = byte_value;

    always_comb
    begin
        if (cls_reg == CLS_NAV && id_reg == ID_PVT && len_reg == PVT_BYTES)
            kind = KIND_PVT;
        else if (cls_reg == CLS_ACK && id_reg == ID_ACK && len_reg >= 16'd2)
            kind = KIND_ACK;
        else if (cls_reg == CLS_ACK && id_reg == ID_NAK && len_reg >= 16'd2)
            kind = KIND_NAK;
        else if (cls_reg == CLS_MON && id_reg == ID_RF && len_reg >= RF_MIN_BYTES)
            kind = KIND_RF;
        else
            kind = KIND_OTHER;
    end

    assign frame_info = '{kind: kind, cls: cls_reg, id: id_reg, len: len_reg};
    assign frame_done = done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SYNC1;
            cls_reg   <= '0;
            id_reg    <= '0;
            len_reg   <= '0;
            idx_reg   <= '0;
            sa_reg    <= '0;
            sb_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cls_reg   <= cls_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            sa_reg    <= sa_next;
            sb_reg    <= sb_next;
        end
    end

endmodule

FILE: rtl/ubx_field_reader.sv
module ubx_field_reader #(
    parameter int BUFFER_BYTES = ubx_pkg::BufferBytesDefault,
    parameter int AW = $clog2(BUFFER_BYTES)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [7:0]           wr_data,
    input  logic                 frame_done,
    input  ubx_pkg::frame_info_t frame_info,
    input  logic [7:0]           fix_threshold,
    output logic                 busy,
    output logic                 valid,
    input  logic                 stall,
    output logic [2:0]           frame_kind,
    output logic [7:0]           msg_class,
    output logic [7:0]           msg_id,
    output logic [4:0]           field_index,
    output logic signed [32:0]   field_value,
    output logic                 last
);
    import ubx_pkg::*;

    typedef enum logic [3:0] {
        RD_IDLE  = 4'b0001,
        RD_ISSUE = 4'b0010,
        RD_TAKE  = 4'b0100,
        RD_OUT   = 4'b1000
    } rd_state_t;

    logic [7:0] mem [BUFFER_BYTES];
    logic [7:0] rdata_reg;

    rd_state_t   st_reg, st_next;
    frame_info_t info_reg, info_next;
    logic [4:0]  fidx_reg, fidx_next;
    logic [2:0]  bcnt_reg, bcnt_next;
    logic [31:0] acc_reg, acc_next;
    logic        valid_reg, valid_next;
    logic [32:0] val_reg, val_next;
    logic [4:0]  oidx_reg, oidx_next;
    logic        olast_reg, olast_next;
    logic [2:0]  okind_reg, okind_next;
    logic [7:0]  ocls_reg, ocls_next, oid_reg, oid_next;
    field_desc_t desc;
    logic [6:0]  rd_off;
    logic [AW-1:0] rd_addr;
    logic [31:0] acc_upd;
    logic        is_fix;

    assign desc    = field_desc(info_reg.kind, fidx_reg);
    assign rd_off  = desc.off + {4'd0, bcnt_reg};
    assign rd_addr = AW'(rd_off);
    assign is_fix  = (info_reg.kind == KIND_PVT) && (fidx_reg == 5'd19);
    assign acc_upd = acc_reg | ({24'd0, rdata_reg} << {bcnt_reg - 3'd1, 3'd0});

    always_ff @(posedge clk)
    begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rdata_reg <= mem[rd_addr];
    end

    always_comb
    begin
        st_next    = st_reg;
        info_next  = info_reg;
        fidx_next  = fidx_reg;
        bcnt_next  = bcnt_reg;
        acc_next   = acc_reg;
        valid_next = valid_reg;
        val_next   = val_reg;
        oidx_next  = oidx_reg;
        olast_next = olast_reg;
        okind_next = okind_reg;
        ocls_next  = ocls_reg;
        oid_next   = oid_reg;
        if (valid_reg && !stall) valid_next = 1'b0;
        case (st_reg)
            RD_IDLE:
            begin
                if (frame_done)
                begin
                    info_next = frame_info;
                    fidx_next = 5'd0;
                    bcnt_next = 3'd0;
                    acc_next  = '0;
                    st_next   = RD_ISSUE;
                end
            end
            RD_ISSUE:
            begin
                // address goes out this cycle, data lands next
                bcnt_next = bcnt_reg + 3'd1;
                st_next   = RD_TAKE;
            end
            RD_TAKE:
            begin
                acc_next = acc_upd;
                if (bcnt_reg == desc.size || info_reg.kind == KIND_OTHER) st_next = RD_OUT;
                else st_next = RD_ISSUE;
            end
            RD_OUT:
            begin
                if (!valid_next)
                begin
                    valid_next = 1'b1;
                    okind_next = info_reg.kind;
                    ocls_next  = info_reg.cls;
                    oid_next   = info_reg.id;
                    oidx_next  = fidx_reg;
                    olast_next = (fidx_reg == field_count(info_reg.kind) - 5'd1);
                    if (info_reg.kind == KIND_OTHER)
                        val_next = {17'd0, info_reg.len};
                    else if (is_fix)
                        val_next = {32'd0, acc_reg[7:0] >= fix_threshold};
                    else
                        val_next = {desc.sgn & acc_reg[31], acc_reg};
                    fidx_next = fidx_reg + 5'd1;
                    bcnt_next = 3'd0;
                    acc_next  = '0;
                    st_next   = olast_next ? RD_IDLE : RD_ISSUE;
                end
            end
            default: st_next = RD_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= RD_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        info_reg  <= info_next;
        fidx_reg  <= fidx_next;
        bcnt_reg  <= bcnt_next;
        acc_reg   <= acc_next;
        val_reg   <= val_next;
        oidx_reg  <= oidx_next;
        olast_reg <= olast_next;
        okind_reg <= okind_next;
        ocls_reg  <= ocls_next;
        oid_reg   <= oid_next;
    end

    assign busy        = (st_reg != RD_IDLE);
    assign valid       = valid_reg;
    assign frame_kind  = okind_reg;
    assign msg_class   = ocls_reg;
    assign msg_id      = oid_reg;
    assign field_index = oidx_reg;
    assign field_value = val_reg;
    assign last        = olast_reg;

endmodule

FILE: rtl/ubx_frame_parser.sv
// channel   | handshake            | payload
// ----------+----------------------+---------------------------------------------
// in        | in_valid / in_stall  | byte_value
// out       | valid / stall        | frame_kind msg_class msg_id field_index
//           |                      | field_value last
// config    | cfg_we               | cfg_data (fix_threshold)
//
// A byte takes one cycle; bytes are held off only while the field reader
// walks a finished frame out of the payload RAM. Each field is read byte by
// byte from the synchronous RAM, an issue state and a take state per byte,
// then presented in an output state. Reset clears the parser to the hunt
// and the threshold to 2; the RAM is not cleared. Output stalls back up into
// the field reader and from there into in_stall.
module ubx_frame_parser #(
    parameter int BUFFER_BYTES = ubx_pkg::BufferBytesDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         byte_value,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_data,
    output logic               valid,
    input  logic               stall,
    output logic [2:0]         frame_kind,
    output logic [7:0]         msg_class,
    output logic [7:0]         msg_id,
    output logic [4:0]         field_index,
    output logic signed [32:0] field_value,
    output logic               last
);
    import ubx_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);

    logic          take, busy, wr_en, frame_done;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    frame_info_t   frame_info;
    logic [7:0]    thr_reg;

    assign in_stall = busy;
    assign take     = in_valid && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) thr_reg <= 8'd2;
        else if (cfg_we) thr_reg <= cfg_data;
    end

    ubx_byte_parser #(.BUFFER_BYTES(BUFFER_BYTES), .AW(AW)) u_parser (
        .clk, .rst_n, .take, .byte_value, .wr_en, .wr_addr, .wr_data,
        .frame_done, .frame_info
    );

    ubx_field_reader #(.BUFFER_BYTES(BUFFER_BYTES), .AW(AW)) u_reader (
        .clk, .rst_n, .wr_en, .wr_addr, .wr_data, .frame_done, .frame_info,
        .fix_threshold(thr_reg), .busy, .valid, .stall, .frame_kind, .msg_class,
        .msg_id, .field_index, .field_value, .last
    );

    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !wr_en) else $error("payload write while reading fields");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |=> busy) else $error("finished frame not picked up");
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> frame_kind <= KIND_OTHER) else $error("bad frame kind");

endmodule

FILE: test/ubx_frame_parser_checker.sv
`timescale 1ns / 100ps

module ubx_frame_parser_checker
    import ubx_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [7:0]         byte_value,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_data,
    input  logic               valid,
    input  logic               stall,
    input  logic [2:0]         frame_kind,
    input  logic [7:0]         msg_class,
    input  logic [7:0]         msg_id,
    input  logic [4:0]         field_index,
    input  logic signed [32:0] field_value,
    input  logic               last,
    output int                 mismatches,
    output int                 outstanding
);

    localparam int StoreBytes = 128;

    typedef enum logic [3:0] {
        PH_HUNT, PH_SYNC2, PH_CLASS, PH_ID, PH_LEN1, PH_LEN2, PH_BODY, PH_CKA, PH_CKB
    } phase_e;

    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  cls;
        logic [7:0]  id;
        logic [4:0]  idx;
        logic [32:0] value;
        logic        last;
    } field_t;

    field_t      decoded_fields[$];
    phase_e      phase;
    logic [7:0]  threshold;
    logic [7:0]  cls_r;
    logic [7:0]  id_r;
    logic [15:0] len_r;
    int unsigned body_pos;
    logic [7:0]  sum_a;
    logic [7:0]  sum_b;
    logic [7:0]  body[StoreBytes];

    const int pvt_off[19]  = '{0, 4, 6, 7, 8, 9, 10, 11, 20, 23, 24, 28, 36, 40, 44, 48, 52,
                               56, 76};
    const int pvt_size[19] = '{4, 2, 1, 1, 1, 1, 1, 1, 1, 1, 4, 4, 4, 4, 4, 4, 4, 4, 2};
    const bit pvt_sgn[19]  = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 0, 0, 1, 1, 1, 0};

    assign outstanding = decoded_fields.size();

    function automatic logic [32:0] le_value(int pos, int size, bit sgn);
        logic [31:0] v;
        v = '0;
        for (int i = 0; i < size; i++)
            v[8*i +: 8] = body[pos + i];
        return {sgn & v[31], v};
    endfunction

    task automatic add_field(logic [2:0] kind, int idx, logic [32:0] value, bit fin);
        field_t f;
        f.kind  = kind;
        f.cls   = cls_r;
        f.id    = id_r;
        f.idx   = idx[4:0];
        f.value = value;
        f.last  = fin;
        decoded_fields.push_back(f);
    endtask

    task automatic decode_frame();
        logic [2:0] kind;
        if (cls_r == CLS_NAV && id_r == ID_PVT && len_r == PVT_BYTES)
        begin
            for (int i = 0; i < 19; i++)
                add_field(KIND_PVT, i, le_value(pvt_off[i], pvt_size[i], pvt_sgn[i]), 0);
            add_field(KIND_PVT, 19, (body[20] >= threshold) ? 33'd1 : 33'd0, 1);
        end
        else if (cls_r == CLS_ACK && (id_r == ID_ACK || id_r == ID_NAK) && len_r >= 16'd2)
        begin
            kind = (id_r == ID_ACK) ? KIND_ACK : KIND_NAK;
            add_field(kind, 0, le_value(0, 1, 0), 0);
            add_field(kind, 1, le_value(1, 1, 0), 1);
        end
        else if (cls_r == CLS_MON && id_r == ID_RF && len_r >= RF_MIN_BYTES)
        begin
            add_field(KIND_RF, 0, le_value(6, 1, 0), 0);
            add_field(KIND_RF, 1, le_value(7, 1, 0), 0);
            add_field(KIND_RF, 2, le_value(12, 2, 0), 0);
            add_field(KIND_RF, 3, le_value(14, 2, 0), 0);
            add_field(KIND_RF, 4, le_value(16, 1, 0), 1);
        end
        else
        begin
            add_field(KIND_OTHER, 0, {17'd0, len_r}, 1);
        end
    endtask

    task automatic parse_byte(logic [7:0] b);
        case (phase)
            PH_HUNT:
                if (b == SYNC_FIRST) phase = PH_SYNC2;
            PH_SYNC2:
                if (b == SYNC_SECOND) phase = PH_CLASS;
                else if (b != SYNC_FIRST) phase = PH_HUNT;
            PH_CLASS:
            begin
                cls_r = b;
                sum_a = b;
                sum_b = b;
                phase = PH_ID;
            end
            PH_ID:
            begin
                id_r  = b;
                sum_a = sum_a + b;
                sum_b = sum_b + sum_a;
                phase = PH_LEN1;
            end
            PH_LEN1:
            begin
                len_r = {8'd0, b};
                sum_a = sum_a + b;
                sum_b = sum_b + sum_a;
                phase = PH_LEN2;
            end
            PH_LEN2:
            begin
                len_r[15:8] = b;
                sum_a = sum_a + b;
                sum_b = sum_b + sum_a;
                body_pos = 0;
                if (len_r > StoreBytes) phase = PH_HUNT;
                else if (len_r == 0) phase = PH_CKA;
                else phase = PH_BODY;
            end
            PH_BODY:
            begin
                if (body_pos < StoreBytes) body[body_pos] = b;
                body_pos++;
                sum_a = sum_a + b;
                sum_b = sum_b + sum_a;
                if (body_pos >= len_r) phase = PH_CKA;
            end
            PH_CKA:
                phase = (b == sum_a) ? PH_CKB : PH_HUNT;
            PH_CKB:
            begin
                phase = PH_HUNT;
                if (b == sum_b) decode_frame();
            end
            default:
                phase = PH_HUNT;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        field_t f;
        if (!rst_n)
        begin
            phase      = PH_HUNT;
            threshold  = 8'd2;
            cls_r      = '0;
            id_r       = '0;
            len_r      = '0;
            body_pos   = 0;
            sum_a      = '0;
            sum_b      = '0;
            mismatches = 0;
            decoded_fields.delete();
        end
        else
        begin
            if (cfg_we) threshold = cfg_data;
            if (in_valid && !in_stall) parse_byte(byte_value);
            if (valid && !stall)
            begin
                if (decoded_fields.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected field transfer kind %0d idx %0d value %0h",
                                 $realtime, frame_kind, field_index, field_value);
                end
                else
                begin
                    f = decoded_fields.pop_front();
                    if (frame_kind !== f.kind || msg_class !== f.cls || msg_id !== f.id ||
                        field_index !== f.idx || field_value !== f.value || last !== f.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: field mismatch: expected kind %0d cls %h id %h ",
                                      "idx %0d value %h last %b, got %0d %h %h %0d %h %b"},
                                     $realtime, f.kind, f.cls, f.id, f.idx, f.value, f.last,
                                     frame_kind, msg_class, msg_id, field_index, field_value,
                                     last);
                    end
                end
            end
        end
    end

endmodule

FILE: test/ubx_frame_parser_tb.sv
`timescale 1ns / 100ps

module ubx_frame_parser_tb;
    import ubx_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         byte_value = '0;
    logic               cfg_we = 1'b0;
    logic [7:0]         cfg_data = '0;
    logic               valid;
    logic               stall = 1'b0;
    logic [2:0]         frame_kind;
    logic [7:0]         msg_class;
    logic [7:0]         msg_id;
    logic [4:0]         field_index;
    logic signed [32:0] field_value;
    logic               last;
    int                 mismatches;
    int                 outstanding;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int bytes_sent = 0;

    always #4 clk = ~clk;

    ubx_frame_parser DUT (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .byte_value(byte_value), .cfg_we(cfg_we), .cfg_data(cfg_data), .valid(valid),
        .stall(stall), .frame_kind(frame_kind), .msg_class(msg_class), .msg_id(msg_id),
        .field_index(field_index), .field_value(field_value), .last(last)
    );

    ubx_frame_parser_checker u_checker (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .byte_value(byte_value), .cfg_we(cfg_we), .cfg_data(cfg_data), .valid(valid),
        .stall(stall), .frame_kind(frame_kind), .msg_class(msg_class), .msg_id(msg_id),
        .field_index(field_index), .field_value(field_value), .last(last),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    always @(posedge clk)
        stall <= ($urandom_range(99) < rx_idle_pct);

    initial
    begin
        #4_000_000;
        $display("ubx_frame_parser_tb: FAIL");
        $finish;
    end

    // hold the byte until the parser takes it; drop valid only for idle gaps
    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        byte_value <= b;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    task automatic go_quiet();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_threshold(logic [7:0] v);
        go_quiet();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // fill: 0 random, 1 all zero, 2 all ones; fault: 0 none, 1 first check, 2 second check
    task automatic send_frame(logic [7:0] cls, logic [7:0] id, logic [15:0] len,
                              int fill, int fault);
        logic [7:0] hdr[4];
        logic [7:0] b;
        logic [7:0] ca;
        logic [7:0] cb;
        hdr = '{cls, id, len[7:0], len[15:8]};
        ca = 0;
        cb = 0;
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        for (int i = 0; i < 4; i++)
        begin
            send_byte(hdr[i]);
            ca = ca + hdr[i];
            cb = cb + ca;
        end
        if (len > 16'd128) return;
        for (int i = 0; i < len; i++)
        begin
            b = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hFF : 8'($urandom);
            if (cls == CLS_NAV && i == 20 && fill == 0 && $urandom_range(3) != 0)
                b = 8'($urandom_range(6));
            send_byte(b);
            ca = ca + b;
            cb = cb + ca;
        end
        send_byte((fault == 1) ? ca ^ 8'($urandom_range(1, 255)) : ca);
        send_byte((fault == 2) ? cb ^ 8'($urandom_range(1, 255)) : cb);
    endtask

    task automatic random_traffic(int target);
        int r;
        int fault;
        target += bytes_sent;
        while (bytes_sent < target)
        begin
            r = $urandom_range(99);
            fault = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : 0;
            if (r < 8)
                send_frame(CLS_NAV, ID_PVT, PVT_BYTES, 0, fault);
            else if (r < 25)
                send_frame(CLS_ACK, $urandom_range(1) ? ID_ACK : ID_NAK,
                           16'($urandom_range(2, 8)), 0, fault);
            else if (r < 35)
                send_frame(CLS_MON, ID_RF, 16'($urandom_range(28, 36)), 0, fault);
            else if (r < 42)
                send_frame(CLS_MON, ID_RF, 16'($urandom_range(0, 27)), 0, fault);
            else if (r < 45)
                send_frame(CLS_ACK, ID_ACK, 16'($urandom_range(0, 1)), 0, fault);
            else if (r < 65)
                send_frame(8'($urandom), 8'($urandom), 16'($urandom_range(0, 24)), 0, fault);
            else if (r < 68)
                send_frame(8'($urandom), 8'($urandom), 16'($urandom_range(93, 128)), 0, fault);
            else if (r < 75)
                send_frame(8'($urandom), 8'($urandom), 16'($urandom_range(129, 65535)), 0, 0);
            else if (r < 82)
            begin
                send_byte(SYNC_FIRST);
                send_byte(SYNC_FIRST);
            end
            else
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes of every frame kind and each drop path
        send_frame(CLS_NAV, ID_PVT, PVT_BYTES, 1, 0);
        send_frame(CLS_ACK, ID_ACK, 16'd2, 2, 0);
        send_frame(CLS_ACK, ID_NAK, 16'd2, 1, 0);
        send_frame(CLS_MON, ID_RF, RF_MIN_BYTES, 2, 0);
        send_frame(CLS_MON, ID_RF, 16'd5, 0, 0);
        send_frame(CLS_NAV, ID_PVT, 16'd12, 0, 0);
        send_frame(8'hFF, 8'hFF, 16'd0, 0, 0);
        send_frame(8'h02, 8'h15, 16'd129, 0, 0);
        send_frame(8'h02, 8'h15, 16'hFFFF, 0, 0);
        send_frame(CLS_ACK, ID_ACK, 16'd2, 0, 1);
        send_frame(CLS_ACK, ID_ACK, 16'd2, 0, 2);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_frame(8'h06, 8'h01, 16'd3, 0, 0);
        send_byte(SYNC_FIRST);
        send_byte(8'h00);
        send_byte(8'h62);

        set_threshold(8'd255);
        send_frame(CLS_NAV, ID_PVT, PVT_BYTES, 2, 0);

        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 78 : 0;
            rx_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 17 : 0;
            set_threshold(8'($urandom_range(1, 6)));
            random_traffic(30);
        end

        go_quiet();
        if (mismatches == 0 && outstanding == 0)
            $display("ubx_frame_parser_tb: PASS");
        else
            $display("ubx_frame_parser_tb: FAIL");
        $finish;
    end

endmodule
